@@ hw/rtl/range_bucketed_location_table_macros.svh @@
`ifndef RANGE_BUCKETED_LOCATION_TABLE_MACROS_SVH
`define RANGE_BUCKETED_LOCATION_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RBLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RBLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rblt_pkg.sv @@
package rblt_pkg;

  localparam int NUM_BUCKETS   = 16;
  localparam int BKT_W         = 4;
  localparam int NUM_THR_REGS  = 5;
  localparam int THR_REG_W     = 48;
  localparam int THR_FIELD_W   = 16;
  localparam int CFG_ADDR_W    = 6;
  localparam int CFG_DATA_W    = 64;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;

  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_FULL       = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND  = 2'd2;
  localparam logic [1:0] STS_UNROUTABLE = 2'd3;

  localparam logic [2:0] REG_ROOT   = 3'd0;
  localparam logic [2:0] REG_GROUP0 = 3'd1;

  localparam logic [1:0] RANGE_TOP = 2'd3;

  localparam logic [THR_REG_W-1:0] THR_RESET [NUM_THR_REGS] = '{
    48'h0050_0032_0014,
    48'h0012_000C_0006,
    48'h002D_0023_0019,
    48'h004B_0041_0037,
    48'h0078_0064_005A
  };

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] range;
  } route_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] mobile_id;
    logic [15:0] mobile_x;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  bucket_index;
    logic [2:0]  bucket_fill;
    logic [15:0] station_x;
  } out_item_t;

endpackage

@@ hw/rtl/range_bucketed_location_table.sv @@
// Channel | Signals                                         | Item
// in      | in_valid, in_ready, in_data                     | action, mobile_id, mobile_x
// out     | out_valid, out_ready, out_data                  | status, bucket, fill, station
// cfg     | psel, penable, pwrite, paddr, pwdata, prdata, pready | 48-bit threshold regs at 8*i
//
// Each item is handled as routing and bucket row read, then row update and write-back.
// The single-port bucket row memory is read once and written at most once per item; one item in flight.
// A new item is taken while the previous result waits, as long as it is taken that cycle.
// rst_n is synchronous, active low; clears counts and control, reloads default thresholds. No clearing pass.
// A stalled out_ready holds the result register and blocks the next item.
`include "range_bucketed_location_table_macros.svh"

module range_bucketed_location_table #(
  parameter int BUCKET_CAPACITY = 4,
  parameter int ID_BITS         = 16,
  parameter int COORD_BITS      = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rblt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rblt_pkg::out_item_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rblt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rblt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rblt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CNT_W = $clog2(BUCKET_CAPACITY + 1);
  localparam int IDX_W = (BUCKET_CAPACITY > 1) ? $clog2(BUCKET_CAPACITY) : 1;

  typedef logic [BUCKET_CAPACITY-1:0][ID_BITS-1:0] row_t;

  function automatic rblt_pkg::route_t route_node(
    input logic [rblt_pkg::THR_REG_W-1:0] thr,
    input logic [COORD_BITS-1:0]          x
  );
    logic [COORD_BITS-1:0] t0;
    logic [COORD_BITS-1:0] t1;
    logic [COORD_BITS-1:0] t2;
    rblt_pkg::route_t      r;
    t0 = thr[0 +: COORD_BITS];
    t1 = thr[rblt_pkg::THR_FIELD_W +: COORD_BITS];
    t2 = thr[2*rblt_pkg::THR_FIELD_W +: COORD_BITS];
    r  = '0;
    if (x < t0) r = '{ok: 1'b1, range: 2'd0};
    if (x > t0 && x < t1) r = '{ok: 1'b1, range: 2'd1};
    if (x > t1 && x < t2) r = '{ok: 1'b1, range: 2'd2};
    if (x > t2) r = '{ok: 1'b1, range: 2'd3};
    return r;
  endfunction

  // configuration
  logic [rblt_pkg::THR_REG_W-1:0] thr_r [rblt_pkg::NUM_THR_REGS];
  logic [2:0]                     cfg_idx;
  logic                           cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rblt_pkg::NUM_THR_REGS; i++) begin
        thr_r[i] <= rblt_pkg::THR_RESET[i];
      end
    end else if (cfg_we && cfg_idx < 3'(rblt_pkg::NUM_THR_REGS)) begin
      thr_r[cfg_idx] <= pwdata[rblt_pkg::THR_REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx < 3'(rblt_pkg::NUM_THR_REGS)) begin
      prdata = rblt_pkg::CFG_DATA_W'(thr_r[cfg_idx]);
    end
  end

  // request routing
  logic                           in_acc;
  logic [COORD_BITS-1:0]          x_in;
  rblt_pkg::route_t               root_rt;
  rblt_pkg::route_t               leaf_rt;
  logic [rblt_pkg::THR_REG_W-1:0] grp_thr;
  logic [1:0]                     st_k;
  logic [COORD_BITS-1:0]          st_field;
  logic [rblt_pkg::BKT_W-1:0]     bkt_nxt;

  assign in_acc = in_valid && in_ready;
  assign x_in   = COORD_BITS'(in_data.mobile_x);

  always_comb begin
    root_rt  = route_node(thr_r[rblt_pkg::REG_ROOT], x_in);
    grp_thr  = thr_r[rblt_pkg::REG_GROUP0 + {1'b0, root_rt.range}];
    leaf_rt  = route_node(grp_thr, x_in);
    bkt_nxt  = {root_rt.range, leaf_rt.range};
    st_k     = (leaf_rt.range == rblt_pkg::RANGE_TOP) ? 2'd2 : leaf_rt.range;
    unique case (st_k)
      2'd0:    st_field = grp_thr[0 +: COORD_BITS];
      2'd1:    st_field = grp_thr[rblt_pkg::THR_FIELD_W +: COORD_BITS];
      default: st_field = grp_thr[2*rblt_pkg::THR_FIELD_W +: COORD_BITS];
    endcase
  end

  // request registers
  logic [1:0]                 act_r;
  logic [ID_BITS-1:0]         id_r;
  logic [rblt_pkg::BKT_W-1:0] bkt_r;
  logic                       routed_r;
  logic [15:0]                station_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r     <= in_data.action;
      id_r      <= ID_BITS'(in_data.mobile_id);
      bkt_r     <= bkt_nxt;
      routed_r  <= root_rt.ok && leaf_rt.ok;
      station_r <= 16'(st_field);
    end
  end

  // bucket row memory
  row_t mem [rblt_pkg::NUM_BUCKETS];
  row_t rd_row_r;
  row_t row_new;
  logic mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[bkt_r] <= row_new;
    end
    if (in_acc) begin
      rd_row_r <= mem[bkt_nxt];
    end
  end

  // fill counts
  logic [CNT_W-1:0] count_r [rblt_pkg::NUM_BUCKETS];
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_new;

  assign cnt_cur = count_r[bkt_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rblt_pkg::NUM_BUCKETS; i++) begin
        count_r[i] <= '0;
      end
    end else if (mem_we) begin
      count_r[bkt_r] <= cnt_new;
    end
  end

  // control
  rblt_pkg::state_t    state_r;
  rblt_pkg::state_t    state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  rblt_pkg::out_item_t out_data_r;
  rblt_pkg::out_item_t out_data_nxt;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;

  assign in_ready  = (state_r == rblt_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < BUCKET_CAPACITY; i++) begin
      if (CNT_W'(i) < cnt_cur && rd_row_r[i] == id_r) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    row_new       = rd_row_r;
    cnt_new       = cnt_cur;
    unique case (state_r)
      rblt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = rblt_pkg::ST_EXEC;
        end
      end
      rblt_pkg::ST_EXEC: begin
        state_nxt                 = rblt_pkg::ST_IDLE;
        out_valid_nxt             = 1'b1;
        out_data_nxt.status       = rblt_pkg::STS_OK;
        out_data_nxt.bucket_index = bkt_r;
        out_data_nxt.station_x    = '0;
        if (!routed_r) begin
          out_data_nxt.status       = rblt_pkg::STS_UNROUTABLE;
          out_data_nxt.bucket_index = '0;
        end else begin
          unique case (act_r)
            rblt_pkg::ACT_INSERT: begin
              if (cnt_cur >= CNT_W'(BUCKET_CAPACITY)) begin
                out_data_nxt.status = rblt_pkg::STS_FULL;
              end else begin
                for (int i = 0; i < BUCKET_CAPACITY; i++) begin
                  if (CNT_W'(i) == cnt_cur) row_new[i] = id_r;
                end
                cnt_new = cnt_cur + CNT_W'(1);
                mem_we  = 1'b1;
              end
            end
            rblt_pkg::ACT_DELETE: begin
              if (!hit) begin
                out_data_nxt.status = rblt_pkg::STS_NOT_FOUND;
              end else begin
                for (int i = 0; i < BUCKET_CAPACITY - 1; i++) begin
                  if (IDX_W'(i) >= hit_idx && CNT_W'(i + 1) < cnt_cur) begin
                    row_new[i] = rd_row_r[i + 1];
                  end
                end
                cnt_new = cnt_cur - CNT_W'(1);
                mem_we  = 1'b1;
              end
            end
            default: begin
              if (hit) begin
                out_data_nxt.station_x = station_r;
              end else begin
                out_data_nxt.status = rblt_pkg::STS_NOT_FOUND;
              end
            end
          endcase
        end
        out_data_nxt.bucket_fill = routed_r ? 3'(cnt_new) : 3'd0;
      end
      default: state_nxt = rblt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rblt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `RBLT_ASSERT_NEXT(a_acc_exec, in_acc, state_r == rblt_pkg::ST_EXEC, "item not executed")
  `RBLT_ASSERT_NOW(a_rose_after_exec, $rose(out_valid_r), $past(state_r) == rblt_pkg::ST_EXEC, "result without item")
  `RBLT_ASSERT_NOW(a_cnt_cap, state_r == rblt_pkg::ST_EXEC, cnt_cur <= CNT_W'(BUCKET_CAPACITY), "fill over capacity")
  `RBLT_ASSERT_NOW(a_unroutable_zero, out_valid_r && out_data_r.status == rblt_pkg::STS_UNROUTABLE, out_data_r.bucket_index == '0 && out_data_r.bucket_fill == '0 && out_data_r.station_x == '0, "unroutable result not cleared")

endmodule
